@@ rtl/core/ocf_pkg.sv @@
package ocf_pkg;

    // sample counter, saturating
    localparam int COUNT_W   = 10;
    localparam int COUNT_MAX = 1023;

    // consecutive over-limit counter, saturating
    localparam int RUN_W   = 6;
    localparam int RUN_MAX = 63;

    // configuration register widths
    localparam int LIMIT_W = 12;
    localparam int SKIP_W  = 10;
    localparam int TRIP_W  = 6;
    localparam int ZREF_W  = 12;

    // voltage fields on the result side
    localparam int VOLT_W = 12;

    // reset values of the configuration registers
    localparam logic [LIMIT_W-1:0] LIMIT_RST = 12'd0;
    localparam logic [SKIP_W-1:0]  SKIP_RST  = 10'd40;
    localparam logic [TRIP_W-1:0]  TRIP_RST  = 6'd20;
    localparam logic [ZREF_W-1:0]  ZREF_RST  = 12'h045;

    // apb port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    typedef enum logic [1:0] {
        REG_LIMIT = 2'd0,
        REG_SKIP  = 2'd1,
        REG_TRIP  = 2'd2,
        REG_ZREF  = 2'd3
    } t_reg_idx;

endpackage

@@ rtl/core/overcurrent_trip_filter.sv @@
// Over-current trip filter. Each s_axis transaction carries one set of ADC samples (current,
// input voltage, output voltage) and yields exactly one m_axis transaction. The first
// CALIBRATION_SAMPLES-1 current samples after reset are averaged to find the zero offset;
// on sample CALIBRATION_SAMPLES the offset becomes zero_reference minus that average and
// offset_ready goes high. Once current_limit is nonzero and skip_count samples have been
// seen, each current sample is offset-corrected (clamped at zero), latched into
// current_value and compared with the limit; trip pulses on the sample where a run of
// over-limit samples reaches trip_run_length increments, and trip_value keeps the value
// that tripped. Throughput is one transaction per clock unless m_axis stalls; each result
// passes through the input register, then the result register. The average is an
// exact divide by CALIBRATION_SAMPLES done as a registered multiply by its reciprocal,
// which runs off the sample sum every clock and is always current by the time the
// calibration sample reaches the result stage. Registers are written over APB at byte
// addresses 0x0 current_limit, 0x4 skip_count, 0x8 trip_run_length, 0xC zero_reference,
// and should only be changed while no transaction is in flight.
module overcurrent_trip_filter #(
    parameter int CALIBRATION_SAMPLES = 1000,
    parameter int SAMPLE_BITS         = 12,
    localparam int IN_TDATA_W  = ((3 * SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_TDATA_W = ((2 * (SAMPLE_BITS + 1) + 2 + 2 * ocf_pkg::VOLT_W + 7) / 8) * 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    // sample stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // current_sample, vin_sample, vout_sample
    input  logic [IN_TDATA_W-1:0]             s_axis_tdata,

    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // current_value, trip, trip_value, offset_ready, vin_value, vout_value
    output logic [OUT_TDATA_W-1:0]            m_axis_tdata,

    // register port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ocf_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [ocf_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [ocf_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import ocf_pkg::*;

    // sum of up to 1023 samples
    localparam int SUM_W   = SAMPLE_BITS + COUNT_W;
    // reciprocal ceil(2^SHIFT / N) gives an exact floor division for any SUM_W-bit sum
    localparam int SHIFT   = SUM_W + COUNT_W;
    localparam int RECIP_W = SHIFT - 3;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(CALIBRATION_SAMPLES) - 64'd1) / 64'(CALIBRATION_SAMPLES);
    localparam int PROD_W  = SUM_W + RECIP_W;
    // corrected current is one bit wider than a sample
    localparam int CUR_W   = SAMPLE_BITS + 1;
    localparam int OFS_W   = ((SAMPLE_BITS > ZREF_W) ? SAMPLE_BITS : ZREF_W) + 2;
    localparam int CORR_W  = OFS_W + 1;
    localparam int CMP_W   = (CUR_W > LIMIT_W) ? CUR_W : LIMIT_W;
    localparam logic [COUNT_W-1:0] CAL_COUNT = COUNT_W'(CALIBRATION_SAMPLES);

    // ---------------- configuration registers ----------------
    logic [LIMIT_W-1:0] r_limit;
    logic [SKIP_W-1:0]  r_skip;
    logic [TRIP_W-1:0]  r_trip_len;
    logic [ZREF_W-1:0]  r_zero_ref;
    logic               w_cfg_wr;
    t_reg_idx           w_reg_idx;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_reg_idx = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit    <= LIMIT_RST;
            r_skip     <= SKIP_RST;
            r_trip_len <= TRIP_RST;
            r_zero_ref <= ZREF_RST;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                REG_LIMIT: r_limit    <= pwdata[LIMIT_W-1:0];
                REG_SKIP:  r_skip     <= pwdata[SKIP_W-1:0];
                REG_TRIP:  r_trip_len <= pwdata[TRIP_W-1:0];
                REG_ZREF:  r_zero_ref <= pwdata[ZREF_W-1:0];
                default:   r_limit    <= r_limit;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_LIMIT: prdata = APB_DATA_W'(r_limit);
            REG_SKIP:  prdata = APB_DATA_W'(r_skip);
            REG_TRIP:  prdata = APB_DATA_W'(r_trip_len);
            REG_ZREF:  prdata = APB_DATA_W'(r_zero_ref);
            default:   prdata = '0;
        endcase
    end

    // ---------------- input stage: sample count and calibration sum ----------------
    logic                   r_in_valid;
    logic [SAMPLE_BITS-1:0] r_in_cur;
    logic [SAMPLE_BITS-1:0] r_in_vin;
    logic [SAMPLE_BITS-1:0] r_in_vout;
    logic [COUNT_W-1:0]     r_in_count;
    logic [COUNT_W-1:0]     r_count;
    logic [COUNT_W-1:0]     n_count;
    logic [SUM_W-1:0]       r_offset_sum;
    logic [PROD_W-1:0]      w_prod;
    logic [SAMPLE_BITS-1:0] r_quot;
    logic                   w_accept;
    logic                   w_move;
    logic                   r_out_valid;

    assign w_move        = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_move;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign n_count = (r_count < COUNT_W'(COUNT_MAX)) ? (r_count + 1'b1) : r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_count      <= '0;
            r_offset_sum <= '0;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
                r_count    <= n_count;
                // samples before the calibration sample feed the average
                if (n_count < CAL_COUNT) begin
                    r_offset_sum <= r_offset_sum + SUM_W'(s_axis_tdata[SAMPLE_BITS-1:0]);
                end
            end else if (w_move) begin
                r_in_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_cur   <= s_axis_tdata[SAMPLE_BITS-1:0];
            r_in_vin   <= s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
            r_in_vout  <= s_axis_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
            r_in_count <= n_count;
        end
    end

    // sum / N, refreshed every clock; the sum is frozen before the calibration
    // sample leaves the input stage
    assign w_prod = PROD_W'(r_offset_sum) * PROD_W'(RECIP_FULL[RECIP_W-1:0]);

    always_ff @(posedge i_clk) begin
        r_quot <= w_prod[SHIFT +: SAMPLE_BITS];
    end

    // ---------------- result stage: correction, limit check, trip ----------------
    logic                     r_calibrated;
    logic signed [OFS_W-1:0]  r_zero_offset;
    logic                     r_prev_over;
    logic [RUN_W-1:0]         r_run;
    logic [CUR_W-1:0]         r_held_cur;
    logic [CUR_W-1:0]         r_held_trip;

    logic                     w_cal;
    logic signed [OFS_W-1:0]  w_ref_s;
    logic signed [OFS_W-1:0]  w_quot_s;
    logic signed [OFS_W-1:0]  n_zero_offset;
    logic signed [CORR_W-1:0] w_cur_s;
    logic signed [CORR_W-1:0] w_corr;
    logic [CUR_W-1:0]         w_val;
    logic                     w_checked;
    logic                     n_over;
    logic [RUN_W-1:0]         n_run;
    logic                     n_trip;
    logic [CUR_W-1:0]         n_held_cur;
    logic [CUR_W-1:0]         n_held_trip;

    assign w_cal    = !r_calibrated && (r_in_count >= CAL_COUNT);
    assign w_ref_s  = OFS_W'(r_zero_ref);
    assign w_quot_s = OFS_W'(r_quot);
    assign n_zero_offset = w_cal ? (w_ref_s - w_quot_s) : r_zero_offset;

    assign w_cur_s = CORR_W'(r_in_cur);
    assign w_corr  = w_cur_s + CORR_W'(n_zero_offset);
    // negative corrected current reads as zero
    assign w_val   = w_corr[CORR_W-1] ? '0 : w_corr[CUR_W-1:0];

    assign w_checked = (r_limit != '0) && (COUNT_W'(r_in_count) >= COUNT_W'(r_skip));
    assign n_over    = w_checked && (CMP_W'(w_val) > CMP_W'(r_limit));

    always_comb begin
        n_run       = r_run;
        n_trip      = 1'b0;
        n_held_trip = r_held_trip;
        if (n_over) begin
            if (r_prev_over) begin
                // saturated run never fires again
                if (r_run < RUN_W'(RUN_MAX)) begin
                    n_run = r_run + 1'b1;
                    if (n_run == RUN_W'(r_trip_len)) begin
                        n_trip      = 1'b1;
                        n_held_trip = w_val;
                    end
                end
            end else begin
                // first over-limit sample of a run
                n_run = '0;
            end
        end
    end

    assign n_held_cur = w_checked ? w_val : r_held_cur;

    logic [CUR_W-1:0]  r_out_cur;
    logic              r_out_trip;
    logic [CUR_W-1:0]  r_out_trip_val;
    logic              r_out_ready;
    logic [VOLT_W-1:0] r_out_vin;
    logic [VOLT_W-1:0] r_out_vout;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid   <= 1'b0;
            r_calibrated  <= 1'b0;
            r_zero_offset <= '0;
            r_prev_over   <= 1'b0;
            r_run         <= '0;
            r_held_cur    <= '0;
            r_held_trip   <= '0;
        end else begin
            if (w_move) begin
                r_out_valid   <= 1'b1;
                r_calibrated  <= r_calibrated || w_cal;
                r_zero_offset <= n_zero_offset;
                r_prev_over   <= n_over;
                r_run         <= n_run;
                r_held_cur    <= n_held_cur;
                r_held_trip   <= n_held_trip;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_out_cur      <= n_held_cur;
            r_out_trip     <= n_trip;
            r_out_trip_val <= n_held_trip;
            r_out_ready    <= r_calibrated || w_cal;
            r_out_vin      <= VOLT_W'(r_in_vin);
            r_out_vout     <= VOLT_W'(r_in_vout);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'({r_out_vout, r_out_vin, r_out_ready,
                                         r_out_trip_val, r_out_trip, r_out_cur});

    // ---------------- assertions ----------------
    // a trip result reports the tripping value as both current and trip value
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_trip) |-> (r_out_trip_val == r_out_cur))
        else $error("trip result with mismatched trip value");

    // calibration never undoes itself
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_calibrated |=> r_calibrated)
        else $error("offset calibration flag dropped");

    // calibration only after the calibration sample has been counted
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_calibrated |-> (r_count >= CAL_COUNT))
        else $error("calibrated before calibration sample");

    // sample counter only grows
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_count >= $past(r_count)))
        else $error("sample counter went backwards");

    // an item held in the input stage stays until it moves to the result stage
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_move) |=> r_in_valid)
        else $error("input stage item lost");

endmodule
